/* hdl/dem_pkg.sv */
package dem_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVEL_W     = 4;

  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_LOCK   = 3'd1;
  localparam logic [2:0] ACT_UNLOCK = 3'd2;
  localparam logic [2:0] ACT_POP    = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic KIND_UNLOCK = 1'b0;
  localparam logic KIND_LOCK   = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] timestamp_ms;
    logic        door_level;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic               event_kind;
    logic [31:0]        event_time;
    logic [31:0]        event_span;
    logic               dropped;
    logic               locked_now;
    logic [31:0]        lock_total;
    logic [31:0]        unlock_total;
    logic [31:0]        locked_span;
    logic [31:0]        unlocked_span;
    logic [LEVEL_W-1:0] queue_level;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

/* hdl/dem_ctrl.sv */
module dem_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dem_pkg::dp_cmd_t cmd
);
  import dem_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_xfer;

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (in_xfer) state_next = ST_EXEC;
        else if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        in_ready  = out_ready && !rst;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_xfer;
  end

endmodule

/* hdl/dem_datapath.sv */
module dem_datapath (
  input  logic              clk,
  input  logic              rst,
  input  dem_pkg::dp_cmd_t  cmd,
  input  dem_pkg::in_item_t in_data,
  output dem_pkg::out_item_t out_data
);
  import dem_pkg::*;

  logic        mem_kind [QUEUE_DEPTH];
  logic [31:0] mem_time [QUEUE_DEPTH];
  logic [31:0] mem_span [QUEUE_DEPTH];

  in_item_t    item;
  logic        rd_kind;
  logic [31:0] rd_time;
  logic [31:0] rd_span;

  logic              door_locked;
  logic [31:0]       last_lock_time;
  logic [31:0]       last_unlock_time;
  logic [31:0]       lock_events;
  logic [31:0]       unlock_events;
  logic [31:0]       locked_span_reg;
  logic [31:0]       unlocked_span_reg;
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [FILL_W-1:0] queue_fill;

  logic              door_locked_next;
  logic [31:0]       last_lock_time_next;
  logic [31:0]       last_unlock_time_next;
  logic [31:0]       lock_events_next;
  logic [31:0]       unlock_events_next;
  logic [31:0]       locked_span_reg_next;
  logic [31:0]       unlocked_span_reg_next;
  logic [PTR_W-1:0]  write_ptr_next;
  logic [PTR_W-1:0]  read_ptr_next;
  logic [FILL_W-1:0] queue_fill_next;
  out_item_t         out_next;

  logic        full;
  logic        push;
  logic        push_kind;
  logic [31:0] push_span;
  logic [31:0] open_span;
  logic        has_open_span;

  assign full          = (queue_fill == FILL_W'(QUEUE_DEPTH));
  assign has_open_span = !door_locked && (last_unlock_time != 32'd0);
  assign open_span     = has_open_span ? (item.timestamp_ms - last_unlock_time) : 32'd0;

  always_comb begin
    door_locked_next       = door_locked;
    last_lock_time_next    = last_lock_time;
    last_unlock_time_next  = last_unlock_time;
    lock_events_next       = lock_events;
    unlock_events_next     = unlock_events;
    locked_span_reg_next   = locked_span_reg;
    unlocked_span_reg_next = unlocked_span_reg;
    write_ptr_next         = write_ptr;
    read_ptr_next          = read_ptr;
    queue_fill_next        = queue_fill;
    push                   = 1'b0;
    push_kind              = KIND_UNLOCK;
    push_span              = 32'd0;
    out_next               = '0;

    unique case (item.action)
      ACT_INIT: begin
        door_locked_next = !item.door_level;
        if (!item.door_level) last_lock_time_next = item.timestamp_ms;
        else                  last_unlock_time_next = item.timestamp_ms;
      end
      ACT_LOCK: begin
        if (has_open_span) unlocked_span_reg_next = open_span;
        door_locked_next    = 1'b1;
        last_lock_time_next = item.timestamp_ms;
        lock_events_next    = lock_events + 32'd1;
        push                = 1'b1;
        push_kind           = KIND_LOCK;
        push_span           = open_span;
      end
      ACT_UNLOCK: begin
        if (door_locked && (last_lock_time != 32'd0))
          locked_span_reg_next = item.timestamp_ms - last_lock_time;
        door_locked_next      = 1'b0;
        last_unlock_time_next = item.timestamp_ms;
        unlock_events_next    = unlock_events + 32'd1;
        push                  = 1'b1;
      end
      ACT_POP: begin
        if (queue_fill != '0) begin
          out_next.event_valid = 1'b1;
          out_next.event_kind  = rd_kind;
          out_next.event_time  = rd_time;
          out_next.event_span  = rd_span;
          read_ptr_next = (read_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : read_ptr + PTR_W'(1);
          queue_fill_next = queue_fill - FILL_W'(1);
        end
      end
      ACT_CLEAR: begin
        lock_events_next       = 32'd0;
        unlock_events_next     = 32'd0;
        locked_span_reg_next   = 32'd0;
        unlocked_span_reg_next = 32'd0;
      end
      default: begin
      end
    endcase

    if (push) begin
      if (full) begin
        out_next.dropped = 1'b1;
      end else begin
        write_ptr_next  = (write_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : write_ptr + PTR_W'(1);
        queue_fill_next = queue_fill + FILL_W'(1);
      end
    end

    out_next.locked_now    = door_locked_next;
    out_next.lock_total    = lock_events_next;
    out_next.unlock_total  = unlock_events_next;
    out_next.locked_span   = locked_span_reg_next;
    out_next.unlocked_span = unlocked_span_reg_next;
    out_next.queue_level   = LEVEL_W'(queue_fill_next);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (cmd.exec && push && !full) begin
      mem_kind[write_ptr] <= push_kind;
      mem_time[write_ptr] <= item.timestamp_ms;
      mem_span[write_ptr] <= push_span;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item    <= in_data;
      rd_kind <= mem_kind[read_ptr];
      rd_time <= mem_time[read_ptr];
      rd_span <= mem_span[read_ptr];
    end
    if (cmd.exec) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      door_locked       <= 1'b0;
      last_lock_time    <= 32'd0;
      last_unlock_time  <= 32'd0;
      lock_events       <= 32'd0;
      unlock_events     <= 32'd0;
      locked_span_reg   <= 32'd0;
      unlocked_span_reg <= 32'd0;
      write_ptr         <= '0;
      read_ptr          <= '0;
      queue_fill        <= '0;
    end else if (cmd.exec) begin
      door_locked       <= door_locked_next;
      last_lock_time    <= last_lock_time_next;
      last_unlock_time  <= last_unlock_time_next;
      lock_events       <= lock_events_next;
      unlock_events     <= unlock_events_next;
      locked_span_reg   <= locked_span_reg_next;
      unlocked_span_reg <= unlocked_span_reg_next;
      write_ptr         <= write_ptr_next;
      read_ptr          <= read_ptr_next;
      queue_fill        <= queue_fill_next;
    end
  end

endmodule

/* hdl/door_event_monitor_fifo.sv */
// Channel | Signals                        | Payload
// in      | in_valid, in_ready, in_data    | action, timestamp_ms, door_level
// out     | out_valid, out_ready, out_data | event and status fields, one per input
//
// The result becomes valid after the input transfer: the transfer edge captures
// the item and reads the queue head, the following update cycle registers the result.
// A new item is taken in the cycle its predecessor's result transfers out,
// so the block takes no new item while its predecessor's result is still pending.
// rst is synchronous; it clears the statistics, pointers and fill count.
// A stalled result holds out_data and blocks further input.
module door_event_monitor_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dem_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dem_pkg::out_item_t out_data
);
  import dem_pkg::*;

  dp_cmd_t cmd;

  dem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dem_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  a_in_only_with_drain: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> out_ready)
    else $error("input taken while result stalled");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid && cmd.exec))
    else $error("no update cycle after input transfer");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.dropped) |-> (out_data.queue_level == LEVEL_W'(QUEUE_DEPTH)))
    else $error("drop reported with queue not full");

  a_pop_not_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.event_valid && out_data.dropped))
    else $error("pop and drop on one result");

endmodule
